FILE: hdl/dqr_pkg.sv
// Shared constants and codes for the double-ended queue with reverse.
`default_nettype none
package dqr_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int WORD_W       = 32;
    localparam int ACTION_W     = 3;
    localparam int STATUS_W     = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_REVERSE    = 3'd4,
        ACT_CLEAR      = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage
`default_nettype wire

FILE: hdl/dqr_mem.sv
// Word store: one write port and two registered read ports.
`default_nettype none
module dqr_mem #(
    parameter int DEPTH = dqr_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_we,
    input  wire logic [AW-1:0]                      i_waddr,
    input  wire logic signed [dqr_pkg::WORD_W-1:0]  i_wdata,
    input  wire logic [AW-1:0]                      i_raddr_a,
    input  wire logic [AW-1:0]                      i_raddr_b,
    output logic signed [dqr_pkg::WORD_W-1:0]       o_rdata_a,
    output logic signed [dqr_pkg::WORD_W-1:0]       o_rdata_b
);

    logic signed [dqr_pkg::WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

FILE: hdl/dqr_ctrl.sv
// Pointer, count and direction control with the action sequencer.
`default_nettype none
module dqr_ctrl #(
    parameter int CAPACITY = dqr_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    input  wire logic [dqr_pkg::ACTION_W-1:0]       i_action,
    output logic                                    busy,
    output logic                                    o_valid,
    output logic [dqr_pkg::STATUS_W-1:0]            o_status,
    output logic [CW-1:0]                           o_count,
    output logic                                    o_rev,
    output logic [AW-1:0]                           o_first,
    output logic [AW-1:0]                           o_last,
    output logic                                    o_we,
    output logic [AW-1:0]                           o_waddr
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } t_state;

    localparam logic [AW-1:0] TOP_SLOT = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    t_state                        r_state, n_state;
    logic [AW-1:0]                 r_first, n_first;
    logic [AW-1:0]                 r_last,  n_last;
    logic [CW-1:0]                 r_count, n_count;
    logic                          r_rev,   n_rev;
    logic [dqr_pkg::STATUS_W-1:0]  r_status, n_status;

    logic          accept;
    logic          at_end;
    logic [AW-1:0] last_inc, last_dec, first_inc, first_dec;
    logic [CW-1:0] count_dec;

    assign accept    = start && !busy;
    assign last_inc  = (r_last == TOP_SLOT) ? '0 : r_last + 1'b1;
    assign last_dec  = (r_last == '0) ? TOP_SLOT : r_last - 1'b1;
    assign first_inc = (r_first == TOP_SLOT) ? '0 : r_first + 1'b1;
    assign first_dec = (r_first == '0) ? TOP_SLOT : r_first - 1'b1;
    assign count_dec = r_count - 1'b1;

    always_comb begin
        n_state  = r_state;
        n_first  = r_first;
        n_last   = r_last;
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = r_status;
        o_we     = 1'b0;
        o_waddr  = r_first;
        at_end   = 1'b0;

        case (r_state)
            S_READ:  n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase

        if (accept) begin
            n_state  = S_READ;
            n_status = dqr_pkg::ST_DONE;
            case (i_action)
                dqr_pkg::ACT_PUSH_BACK, dqr_pkg::ACT_PUSH_FRONT: begin
                    // The physical end follows the direction flag.
                    at_end = (i_action == dqr_pkg::ACT_PUSH_BACK) ? !r_rev : r_rev;
                    if (r_count >= FULL_CNT) begin
                        n_status = dqr_pkg::ST_FULL;
                    end else begin
                        o_we    = 1'b1;
                        n_count = r_count + 1'b1;
                        if (r_count == '0) begin
                            n_last  = r_first;
                            o_waddr = r_first;
                        end else if (at_end) begin
                            n_last  = last_inc;
                            o_waddr = last_inc;
                        end else begin
                            n_first = first_dec;
                            o_waddr = first_dec;
                        end
                    end
                end
                dqr_pkg::ACT_POP_BACK, dqr_pkg::ACT_POP_FRONT: begin
                    at_end = (i_action == dqr_pkg::ACT_POP_BACK) ? !r_rev : r_rev;
                    if (r_count == '0) begin
                        n_status = dqr_pkg::ST_EMPTY;
                    end else begin
                        n_count = count_dec;
                        if (count_dec == '0) begin
                            n_last = r_first;
                        end else if (at_end) begin
                            n_last = last_dec;
                        end else begin
                            n_first = first_inc;
                        end
                    end
                end
                dqr_pkg::ACT_REVERSE: begin
                    n_rev = !r_rev;
                end
                dqr_pkg::ACT_CLEAR: begin
                    n_count = '0;
                    n_first = '0;
                    n_last  = '0;
                    n_rev   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_first  <= '0;
            r_last   <= '0;
            r_count  <= '0;
            r_rev    <= 1'b0;
            r_status <= dqr_pkg::ST_DONE;
        end else begin
            r_state  <= n_state;
            r_first  <= n_first;
            r_last   <= n_last;
            r_count  <= n_count;
            r_rev    <= n_rev;
            r_status <= n_status;
        end
    end

    assign busy     = (r_state == S_READ);
    assign o_valid  = (r_state == S_OUT);
    assign o_status = r_status;
    assign o_count  = r_count;
    assign o_rev    = r_rev;
    assign o_first  = r_first;
    assign o_last   = r_last;

endmodule
`default_nettype wire

FILE: hdl/double_ended_queue_with_reverse_top.sv
// Top level of the bounded double-ended queue with a reverse action.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------------
//  action in | start, busy            | i_action, i_value
//  result out| o_valid (strobe only)  | o_status, o_count, o_front_value, o_back_value
//
// In the accept cycle the pointers, the count and the direction flag are
// updated and a pushed word is written to the store. In the following cycle
// busy is high while the store is read at both end slots; the store's read
// port is registered. The result beat is then shown for one cycle with
// o_valid, and a new action may be accepted in that same cycle; no new action
// is accepted while busy is high. Reset is synchronous and active low; it
// empties the queue and restores normal order, while the store contents stay
// as they were. The receiver cannot stall, so no result is ever held back.
`default_nettype none
module double_ended_queue_with_reverse_top #(
    parameter int CAPACITY = dqr_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [dqr_pkg::ACTION_W-1:0]       i_action,
    input  wire logic signed [dqr_pkg::WORD_W-1:0]  i_value,
    output logic                                    o_valid,
    output logic [dqr_pkg::STATUS_W-1:0]            o_status,
    output logic [CW-1:0]                           o_count,
    output logic signed [dqr_pkg::WORD_W-1:0]       o_front_value,
    output logic signed [dqr_pkg::WORD_W-1:0]       o_back_value
);

    logic                              rev;
    logic [AW-1:0]                     first_slot, last_slot, waddr;
    logic                              we;
    logic signed [dqr_pkg::WORD_W-1:0] first_word, last_word;

    dqr_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_status (o_status),
        .o_count  (o_count),
        .o_rev    (rev),
        .o_first  (first_slot),
        .o_last   (last_slot),
        .o_we     (we),
        .o_waddr  (waddr)
    );

    // The store is read at both end slots every cycle; the words captured
    // at the end of the busy cycle belong to the state after the action.
    dqr_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (i_value),
        .i_raddr_a (first_slot),
        .i_raddr_b (last_slot),
        .o_rdata_a (first_word),
        .o_rdata_b (last_word)
    );

    // When reversed, the last physical slot is the logical front. An empty
    // queue reports zero at both ends.
    always_comb begin
        if (o_count == '0) begin
            o_front_value = '0;
            o_back_value  = '0;
        end else if (rev) begin
            o_front_value = last_word;
            o_back_value  = first_word;
        end else begin
            o_front_value = first_word;
            o_back_value  = last_word;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/dqr_checker.sv
// Port-level checks for the double-ended queue, bound to its top level.
`default_nettype none
module dqr_checker #(
    parameter int CAPACITY = dqr_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               start,
    input wire logic                               busy,
    input wire logic                               o_valid,
    input wire logic [dqr_pkg::STATUS_W-1:0]       o_status,
    input wire logic [CW-1:0]                      o_count,
    input wire logic signed [dqr_pkg::WORD_W-1:0]  o_front_value,
    input wire logic signed [dqr_pkg::WORD_W-1:0]  o_back_value
);

    // An accepted action is followed by busy, without o_valid, and then by a result beat.
    a_accept_to_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid) ##1 o_valid)
        else $error("accepted action did not give a result beat in time");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_count == '0) |-> (o_front_value == '0 && o_back_value == '0))
        else $error("empty queue reported a non-zero end word");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dqr_pkg::ST_FULL) |-> (o_count == CW'(CAPACITY)))
        else $error("full status with a count below capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dqr_pkg::ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with a non-zero count");

endmodule

bind double_ended_queue_with_reverse_top dqr_checker #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
) u_dqr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_count       (o_count),
    .o_front_value (o_front_value),
    .o_back_value  (o_back_value)
);
`default_nettype wire

FILE: bench/double_ended_queue_with_reverse_top_tb.sv
// Self-checking testbench for the double-ended queue with reverse: directed and random beats.
`timescale 1ns / 100ps
`default_nettype none
module double_ended_queue_with_reverse_top_tb;

    // The store depth and the width of the count port follow the block's defaults.
    localparam int DEPTH     = dqr_pkg::CAPACITY_DEF;
    localparam int CNT_W     = $clog2(dqr_pkg::CAPACITY_DEF + 1);
    // Action codes that the block must ignore while still reporting its state.
    localparam logic [dqr_pkg::ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [dqr_pkg::ACTION_W-1:0] ACT_SPARE_B = 3'd7;
    // Number of beats to issue in the random part.
    localparam int RANDOM_BEATS = 800;
    // Once no more than this many beats are still waiting, the sender stops idling.
    localparam int CALM_TAIL = 150;
    // Cycles allowed after the last result for stray beats to show up.
    localparam int SETTLE_CYCLES = 8;
    // Hard stop: far beyond the slowest correct run.
    localparam int CYCLE_LIMIT = 200000;

    // One action waiting to be sent, optionally held back until the queue of
    // expected results has run dry.
    typedef struct {
        logic [dqr_pkg::ACTION_W-1:0] action;
        logic [dqr_pkg::WORD_W-1:0]   value;
        bit                           drain;
    } t_deque_cmd;

    // What one result beat should carry.
    typedef struct {
        logic [dqr_pkg::STATUS_W-1:0] status;
        logic [CNT_W-1:0]             count;
        logic [dqr_pkg::WORD_W-1:0]   front;
        logic [dqr_pkg::WORD_W-1:0]   back;
    } t_deque_view;

    logic                                i_clk    = 1'b0;
    logic                                i_rst_n  = 1'b0;
    logic                                start    = 1'b0;
    logic [dqr_pkg::ACTION_W-1:0]        i_action = dqr_pkg::ACT_PUSH_BACK;
    logic signed [dqr_pkg::WORD_W-1:0]   i_value  = '0;
    wire logic                           busy;
    wire logic                           o_valid;
    wire logic [dqr_pkg::STATUS_W-1:0]   o_status;
    wire logic [CNT_W-1:0]               o_count;
    wire logic signed [dqr_pkg::WORD_W-1:0] o_front_value;
    wire logic signed [dqr_pkg::WORD_W-1:0] o_back_value;

    t_deque_cmd  cmds_to_send[$];
    t_deque_view views_due[$];
    int          errors    = 0;
    int          gap_left  = 0;
    int          cycles    = 0;
    int          beats_put = 0;

    // Shadow copy of the queue: a circular store with a first and a last slot,
    // a count of live words and the direction flag. Only live slots are read.
    logic [dqr_pkg::WORD_W-1:0] shadow_store [DEPTH];
    int                         head_slot = 0;
    int                         tail_slot = 0;
    int                         held      = 0;
    bit                         flipped   = 1'b0;

    double_ended_queue_with_reverse_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_count       (o_count),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value)
    );

    // Two-nanosecond clock: one nanosecond high, one low.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int slot_after(int s);
        return (s + 1 >= DEPTH) ? 0 : s + 1;
    endfunction

    function automatic int slot_before(int s);
        return (s == 0) ? DEPTH - 1 : s - 1;
    endfunction

    // Applies one action to the shadow queue and returns the result beat that
    // the block should produce for it. With the flag set, the logical back is
    // the first slot and the logical front is the last slot, so each end-based
    // action is mapped to the physical end it really touches.
    function automatic t_deque_view deque_apply(logic [dqr_pkg::ACTION_W-1:0] act,
                                                logic [dqr_pkg::WORD_W-1:0] word);
        t_deque_view v;
        bit          at_tail;
        v.status = dqr_pkg::ST_DONE;
        case (act)
            dqr_pkg::ACT_PUSH_BACK, dqr_pkg::ACT_PUSH_FRONT: begin
                at_tail = (act == dqr_pkg::ACT_PUSH_BACK) ? !flipped : flipped;
                if (held >= DEPTH) begin
                    v.status = dqr_pkg::ST_FULL;
                end else begin
                    // The first word of an empty queue lands at the first slot.
                    if (held == 0) begin
                        tail_slot = head_slot;
                    end else if (at_tail) begin
                        tail_slot = slot_after(tail_slot);
                    end else begin
                        head_slot = slot_before(head_slot);
                    end
                    shadow_store[at_tail ? tail_slot : head_slot] = word;
                    held++;
                end
            end
            dqr_pkg::ACT_POP_BACK, dqr_pkg::ACT_POP_FRONT: begin
                at_tail = (act == dqr_pkg::ACT_POP_BACK) ? !flipped : flipped;
                if (held == 0) begin
                    v.status = dqr_pkg::ST_EMPTY;
                end else begin
                    held--;
                    if (held == 0) begin
                        tail_slot = head_slot;
                    end else if (at_tail) begin
                        tail_slot = slot_before(tail_slot);
                    end else begin
                        head_slot = slot_after(head_slot);
                    end
                end
            end
            dqr_pkg::ACT_REVERSE: begin
                flipped = !flipped;
            end
            dqr_pkg::ACT_CLEAR: begin
                held      = 0;
                head_slot = 0;
                tail_slot = 0;
                flipped   = 1'b0;
            end
            default: begin
                // Spare codes change nothing.
            end
        endcase
        v.count = held[CNT_W-1:0];
        if (held == 0) begin
            v.front = '0;
            v.back  = '0;
        end else if (flipped) begin
            v.front = shadow_store[tail_slot];
            v.back  = shadow_store[head_slot];
        end else begin
            v.front = shadow_store[head_slot];
            v.back  = shadow_store[tail_slot];
        end
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [dqr_pkg::WORD_W-1:0] got,
                                   logic [dqr_pkg::WORD_W-1:0] want);
        $display("[%0t] mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic queue_action(logic [dqr_pkg::ACTION_W-1:0] act,
                                logic [dqr_pkg::WORD_W-1:0] word,
                                bit drain = 1'b0);
        t_deque_cmd c;
        c.action = act;
        c.value  = word;
        c.drain  = drain;
        cmds_to_send.push_back(c);
        // Spare codes are merely ignored by the block and do not count.
        if (act <= dqr_pkg::ACT_CLEAR) begin
            beats_put++;
        end
    endtask

    // Push data leans towards the extremes of the signed range now and then.
    function automatic logic [dqr_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Driver. A beat is accepted at an edge where start is high and busy is
    // low; its result is predicted at that moment. After acceptance the sender
    // may idle for a random burst, and a command marked for draining is held
    // back until every outstanding result has been checked. The next value of
    // start is settled in a variable so that it gets a single assignment.
    always @(posedge i_clk) begin
        logic       next_start;
        t_deque_cmd c;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_action <= dqr_pkg::ACT_PUSH_BACK;
            i_value  <= '0;
            gap_left = 0;
        end else begin
            next_start = start;
            if (start && !busy) begin
                views_due.push_back(deque_apply(i_action, i_value));
                next_start = 1'b0;
                if (cmds_to_send.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 16);
                end
            end
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmds_to_send.size() != 0 &&
                             !(cmds_to_send[0].drain && views_due.size() != 0)) begin
                    c = cmds_to_send.pop_front();
                    i_action   <= c.action;
                    i_value    <= c.value;
                    next_start = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    // Monitor. A result beat is present for exactly one cycle and is taken at
    // the edge that ends it; it is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_deque_view want;
        if (i_rst_n && o_valid) begin
            if (views_due.size() == 0) begin
                report_mismatch("unexpected result beat", o_front_value, '0);
            end else begin
                want = views_due.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                end
                if (o_count !== want.count) begin
                    report_mismatch("count", 32'(o_count), 32'(want.count));
                end
                if (o_front_value !== want.front) begin
                    report_mismatch("front value", o_front_value, want.front);
                end
                if (o_back_value !== want.back) begin
                    report_mismatch("back value", o_back_value, want.back);
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("double_ended_queue_with_reverse_top regression: fail");
            $finish;
        end
    end

    initial begin
        int beats_wanted;
        int n_push;
        int n_pop;
        int k;
        int r;

        // Directed part: pops and a reverse on the empty queue, pushes of the
        // extreme words at both ends while reversed, pops from both ends, the
        // spare codes, a clear while reversed, and a reverse with one entry.
        queue_action(dqr_pkg::ACT_POP_BACK, 32'h1234_5678);
        queue_action(dqr_pkg::ACT_POP_FRONT, 32'hffff_ffff);
        queue_action(dqr_pkg::ACT_REVERSE, '0);
        queue_action(dqr_pkg::ACT_PUSH_BACK, 32'h7fff_ffff);
        queue_action(dqr_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
        queue_action(dqr_pkg::ACT_PUSH_BACK, 32'hffff_ffff);
        queue_action(dqr_pkg::ACT_PUSH_FRONT, 32'h0000_0000);
        queue_action(dqr_pkg::ACT_REVERSE, '0);
        queue_action(dqr_pkg::ACT_POP_FRONT, '0);
        queue_action(dqr_pkg::ACT_POP_BACK, '0);
        queue_action(ACT_SPARE_A, 32'h5555_5555);
        queue_action(ACT_SPARE_B, 32'hffff_ffff);
        queue_action(dqr_pkg::ACT_PUSH_FRONT, 32'haaaa_aaaa);
        queue_action(dqr_pkg::ACT_PUSH_BACK, 32'h5555_5555);
        queue_action(dqr_pkg::ACT_REVERSE, '0);
        queue_action(dqr_pkg::ACT_CLEAR, 32'hffff_ffff);
        queue_action(dqr_pkg::ACT_PUSH_FRONT, 32'h0000_0001);
        queue_action(dqr_pkg::ACT_REVERSE, '0);
        queue_action(dqr_pkg::ACT_POP_BACK, '0);
        queue_action(dqr_pkg::ACT_POP_FRONT, '0);
        queue_action(dqr_pkg::ACT_PUSH_BACK, 32'h8000_0001);

        // Random part. Most of it is bursts of mixed actions that lean towards
        // pushes, so the level wanders up and down; now and then a whole
        // fill-to-full and drain-to-empty sequence drives both boundaries.
        // The first random beat waits until the directed results are all in.
        beats_wanted = beats_put + RANDOM_BEATS;
        queue_action(dqr_pkg::ACT_REVERSE, '0, 1'b1);
        while (beats_put < beats_wanted) begin
            if ($urandom_range(0, 7) == 0) begin
                queue_action(dqr_pkg::ACT_CLEAR, pick_word(), $urandom_range(0, 3) == 0);
                n_push = DEPTH + $urandom_range(1, 3);
                for (k = 0; k < n_push; k++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        queue_action(dqr_pkg::ACT_REVERSE, pick_word());
                    end
                    queue_action($urandom_range(0, 1) ? dqr_pkg::ACT_PUSH_BACK
                                                      : dqr_pkg::ACT_PUSH_FRONT,
                                 pick_word());
                end
                n_pop = DEPTH + $urandom_range(1, 2);
                for (k = 0; k < n_pop; k++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        queue_action(dqr_pkg::ACT_REVERSE, pick_word());
                    end
                    queue_action($urandom_range(0, 1) ? dqr_pkg::ACT_POP_BACK
                                                      : dqr_pkg::ACT_POP_FRONT,
                                 pick_word());
                end
            end else begin
                for (k = 0; k < 24; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 25) begin
                        queue_action(dqr_pkg::ACT_PUSH_BACK, pick_word(), k == 0 && r < 3);
                    end else if (r < 50) begin
                        queue_action(dqr_pkg::ACT_PUSH_FRONT, pick_word());
                    end else if (r < 65) begin
                        queue_action(dqr_pkg::ACT_POP_BACK, pick_word());
                    end else if (r < 80) begin
                        queue_action(dqr_pkg::ACT_POP_FRONT, pick_word());
                    end else if (r < 91) begin
                        queue_action(dqr_pkg::ACT_REVERSE, pick_word());
                    end else if (r < 94) begin
                        queue_action(dqr_pkg::ACT_CLEAR, pick_word());
                    end else begin
                        queue_action($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B,
                                     pick_word());
                    end
                end
            end
        end

        // Synchronous reset, released after the command list is built.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every command has been accepted and every result seen,
        // then leave SETTLE_CYCLES for any stray result beat.
        @(posedge i_clk);
        while (cmds_to_send.size() != 0 || start || views_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (errors == 0 && views_due.size() == 0) begin
            $display("double_ended_queue_with_reverse_top regression: pass");
        end else begin
            $display("double_ended_queue_with_reverse_top regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: double_ended_queue_with_reverse_top.f
hdl/dqr_pkg.sv
hdl/dqr_mem.sv
hdl/dqr_ctrl.sv
hdl/double_ended_queue_with_reverse_top.sv
hdl/dqr_checker.sv
bench/double_ended_queue_with_reverse_top_tb.sv
